// ===== rtl/mu8_pkg.sv =====
// shared types and constants for the modified utf-8 string decoder
`default_nettype none

package mu8_pkg;

   // result status codes
   localparam logic [1:0] STAT_CHAR      = 2'd0;
   localparam logic [1:0] STAT_EMPTY     = 2'd1;
   localparam logic [1:0] STAT_MALFORMED = 2'd2;

   // header length in bytes, counted from zero
   localparam logic [1:0] HDR_LAST = 2'd3;

   // lead nibble codes
   localparam logic [3:0] NIB_TWO_A = 4'hC;
   localparam logic [3:0] NIB_TWO_B = 4'hD;
   localparam logic [3:0] NIB_THREE = 4'hE;

   // payload masks
   localparam logic [7:0] MASK_TWO   = 8'h1F;
   localparam logic [7:0] MASK_THREE = 8'h0F;
   localparam logic [7:0] MASK_CONT  = 8'h3F;

   // decoder state
   typedef struct packed {
      logic        in_payload;
      logic [1:0]  hdr_cnt;
      logic [31:0] remain;
      logic [15:0] partial;
      logic [1:0]  cont;
   } state_type;

   // one result beat
   typedef struct packed {
      logic        valid;
      logic [15:0] char_out;
      logic [1:0]  status;
      logic        eos;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/modified_utf8_string_decoder_core.sv =====
// top level: input register, byte decoder and result register
// path: an accepted byte is held in the input register, decoded, and its result registered in the result register
// throughput: one byte per cycle while no result is held back by a low rsp_ready
// bytes of a nonzero length header and well-formed lead or middle bytes of a sequence give no result
// reset: synchronous active high, clears decoder state and both valid flags
// after reset the next byte is taken as the first length byte
`default_nettype none

module modified_utf8_string_decoder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_byte_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_char_out,
   output logic [1:0]       rsp_status,
   output logic             rsp_end_of_string
);

   logic                in_vld_ff;
   logic [7:0]          in_byte_ff;
   mu8_pkg::state_type  state_ff;
   mu8_pkg::state_type  state_in;
   mu8_pkg::result_type res;
   logic                out_vld_ff;
   logic [15:0]         out_char_ff;
   logic [1:0]          out_status_ff;
   logic                out_eos_ff;
   logic                fire;

   // decode the registered byte
   mu8_step u_step (
      .cur     (state_ff),
      .byte_in (in_byte_ff),
      .nxt     (state_in),
      .res     (res)
   );

   // input stage advances unless a result is blocked
   assign fire      = in_vld_ff && (!res.valid || !out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || fire;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_byte_in;
      end
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (fire && res.valid) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
      if (fire && res.valid) begin
         out_char_ff   <= res.char_out;
         out_status_ff <= res.status;
         out_eos_ff    <= res.eos;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_char_out      = out_char_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_end_of_string = out_eos_ff;

endmodule

`default_nettype wire

// ===== rtl/mu8_step.sv =====
// next-state and result logic for one stream byte
`default_nettype none

module mu8_step (
   input  wire mu8_pkg::state_type  cur,
   input  wire logic [7:0]          byte_in,
   output mu8_pkg::state_type       nxt,
   output mu8_pkg::result_type      res
);

   logic [31:0] shifted;
   logic [31:0] dec;
   logic [3:0]  nib;
   logic [1:0]  cont_dec;
   logic [15:0] merged;

   assign shifted  = (cur.hdr_cnt == 2'd0) ? {24'd0, byte_in} : {cur.remain[23:0], byte_in};
   assign dec      = cur.remain - 32'd1;
   assign nib      = byte_in[7:4];
   assign cont_dec = cur.cont - 2'd1;
   assign merged   = {cur.partial[9:0], byte_in[5:0]};

   // decode one byte against the current state
   always_comb begin
      nxt = cur;
      res = '0;
      if (!cur.in_payload) begin
         // length header
         if (cur.hdr_cnt != mu8_pkg::HDR_LAST) begin
            nxt.hdr_cnt = cur.hdr_cnt + 2'd1;
            nxt.remain  = shifted;
         end else if (shifted == 32'd0) begin
            nxt        = '0;
            res.valid  = 1'b1;
            res.status = mu8_pkg::STAT_EMPTY;
            res.eos    = 1'b1;
         end else begin
            nxt            = '0;
            nxt.in_payload = 1'b1;
            nxt.remain     = shifted;
         end
      end else if (cur.cont == 2'd0) begin
         // lead byte
         if (!nib[3]) begin
            nxt.remain   = dec;
            res.valid    = 1'b1;
            res.status   = mu8_pkg::STAT_CHAR;
            res.char_out = {8'd0, byte_in};
            if (dec == 32'd0) begin
               nxt     = '0;
               res.eos = 1'b1;
            end
         end else if ((nib == mu8_pkg::NIB_TWO_A || nib == mu8_pkg::NIB_TWO_B)
                      && cur.remain >= 32'd2) begin
            nxt.partial = {8'd0, byte_in & mu8_pkg::MASK_TWO};
            nxt.cont    = 2'd1;
            nxt.remain  = dec;
         end else if (nib == mu8_pkg::NIB_THREE && cur.remain >= 32'd3) begin
            nxt.partial = {8'd0, byte_in & mu8_pkg::MASK_THREE};
            nxt.cont    = 2'd2;
            nxt.remain  = dec;
         end else begin
            nxt        = '0;
            res.valid  = 1'b1;
            res.status = mu8_pkg::STAT_MALFORMED;
            res.eos    = 1'b1;
         end
      end else if (byte_in[7:6] != 2'b10) begin
         // bad continuation
         nxt        = '0;
         res.valid  = 1'b1;
         res.status = mu8_pkg::STAT_MALFORMED;
         res.eos    = 1'b1;
      end else begin
         // good continuation
         nxt.cont   = cont_dec;
         nxt.remain = dec;
         if (cont_dec != 2'd0) begin
            nxt.partial = merged;
         end else begin
            nxt.partial  = 16'd0;
            res.valid    = 1'b1;
            res.status   = mu8_pkg::STAT_CHAR;
            res.char_out = merged;
            if (dec == 32'd0) begin
               nxt     = '0;
               res.eos = 1'b1;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mu8_checker.sv =====
// port-level checks for the modified utf-8 string decoder
`default_nettype none

module mu8_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_char_out,
   input wire logic [1:0]  rsp_status,
   input wire logic        rsp_end_of_string
);

   // no result beat right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // status is one of the defined codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == mu8_pkg::STAT_CHAR || rsp_status == mu8_pkg::STAT_EMPTY ||
                     rsp_status == mu8_pkg::STAT_MALFORMED))
      else $error("undefined status code");

   // empty and malformed results close the string and carry no character
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != mu8_pkg::STAT_CHAR) |->
         (rsp_end_of_string && rsp_char_out == 16'd0))
      else $error("non-character result without end mark or with data");

   // stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_char_out) &&
         $stable(rsp_status) && $stable(rsp_end_of_string)))
      else $error("stalled result beat changed");

endmodule

bind modified_utf8_string_decoder_core mu8_checker u_mu8_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_char_out      (rsp_char_out),
   .rsp_status        (rsp_status),
   .rsp_end_of_string (rsp_end_of_string)
);

`default_nettype wire

// ===== tb/tb_modified_utf8_string_decoder_core.sv =====
// testbench for the modified utf-8 string decoder: directed and random byte streams
`timescale 1ns / 100ps

module tb_modified_utf8_string_decoder_core;

   // limit on cycles with no beat on either side before the run is declared hung
   localparam int HANG_LIMIT = 1000;
   localparam int RANDOM_ITEMS = 780;
   localparam int TOTAL_ITEMS = 850;
   localparam int DRAIN_CYCLES = 8;

   // bytes used to force the decoder back to waiting for a count
   localparam logic [7:0] RESYNC_LEAD = 8'h80;
   localparam logic [7:0] RESYNC_FILL = 8'h00;
   localparam logic [1:0] CONT_TAG = 2'b10;
   localparam logic [2:0] LEAD_TWO_TAG = 3'b110;
   localparam logic [3:0] LEAD_THREE_TAG = 4'b1110;

   typedef struct packed {
      logic [15:0] ch;
      logic [1:0]  status;
      logic        eos;
   } char_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_byte_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_char_out;
   logic [1:0]  rsp_status;
   logic        rsp_end_of_string;

   // decoder state as the predictor sees it
   mu8_pkg::state_type dec_state = '0;
   char_beat_type      pending_chars[$];
   logic [7:0]         string_bytes[$];
   int                 items_sent = 0;
   int                 errors = 0;
   int                 quiet_cycles = 0;
   int                 stall_left = 0;
   bit                 idle_on = 1'b1;

   modified_utf8_string_decoder_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_byte_in       (req_byte_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_char_out      (rsp_char_out),
      .rsp_status        (rsp_status),
      .rsp_end_of_string (rsp_end_of_string)
   );

   // 2 ns clock
   initial begin
      forever #1 clock = ~clock;
   end

   task automatic push_char(input logic [15:0] ch, input logic [1:0] status,
                            input logic eos);
      char_beat_type beat;
      beat.ch = ch;
      beat.status = status;
      beat.eos = eos;
      pending_chars.push_back(beat);
   endtask

   task automatic flag_malformed();
      dec_state = '0;
      push_char(16'h0000, mu8_pkg::STAT_MALFORMED, 1'b1);
   endtask

   // advance the decoder state by one accepted byte and queue any result
   task automatic decode_byte(input logic [7:0] b);
      logic [15:0] ch;
      if (!dec_state.in_payload) begin
         if (dec_state.hdr_cnt == 2'd0)
            dec_state.remain = {24'd0, b};
         else
            dec_state.remain = {dec_state.remain[23:0], b};
         if (dec_state.hdr_cnt != mu8_pkg::HDR_LAST) begin
            dec_state.hdr_cnt = dec_state.hdr_cnt + 2'd1;
         end else begin
            dec_state.hdr_cnt = 2'd0;
            dec_state.partial = 16'h0000;
            dec_state.cont = 2'd0;
            if (dec_state.remain == 32'd0) begin
               dec_state = '0;
               push_char(16'h0000, mu8_pkg::STAT_EMPTY, 1'b1);
            end else begin
               dec_state.in_payload = 1'b1;
            end
         end
      end else if (dec_state.cont == 2'd0) begin
         // lead byte
         if (!b[7]) begin
            dec_state.remain = dec_state.remain - 32'd1;
            if (dec_state.remain == 32'd0) begin
               dec_state = '0;
               push_char({8'h00, b}, mu8_pkg::STAT_CHAR, 1'b1);
            end else begin
               push_char({8'h00, b}, mu8_pkg::STAT_CHAR, 1'b0);
            end
         end else if (b[7:4] == mu8_pkg::NIB_TWO_A || b[7:4] == mu8_pkg::NIB_TWO_B) begin
            if (dec_state.remain < 32'd2) begin
               flag_malformed();
            end else begin
               dec_state.partial = {8'h00, b & mu8_pkg::MASK_TWO};
               dec_state.cont = 2'd1;
               dec_state.remain = dec_state.remain - 32'd1;
            end
         end else if (b[7:4] == mu8_pkg::NIB_THREE) begin
            if (dec_state.remain < 32'd3) begin
               flag_malformed();
            end else begin
               dec_state.partial = {8'h00, b & mu8_pkg::MASK_THREE};
               dec_state.cont = 2'd2;
               dec_state.remain = dec_state.remain - 32'd1;
            end
         end else begin
            flag_malformed();
         end
      end else if (b[7:6] != CONT_TAG) begin
         flag_malformed();
      end else begin
         // continuation byte
         dec_state.partial = {dec_state.partial[9:0], b[5:0]};
         dec_state.cont = dec_state.cont - 2'd1;
         dec_state.remain = dec_state.remain - 32'd1;
         if (dec_state.cont == 2'd0) begin
            ch = dec_state.partial;
            dec_state.partial = 16'h0000;
            if (dec_state.remain == 32'd0) begin
               dec_state = '0;
               push_char(ch, mu8_pkg::STAT_CHAR, 1'b1);
            end else begin
               push_char(ch, mu8_pkg::STAT_CHAR, 1'b0);
            end
         end
      end
   endtask

   // drive one byte beat, with an optional gap first, and wait for acceptance
   task automatic send_byte(input logic [7:0] b);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_in <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_byte(b);
      items_sent++;
   endtask

   task automatic send_string(input logic [31:0] count);
      send_byte(count[31:24]);
      send_byte(count[23:16]);
      send_byte(count[15:8]);
      send_byte(count[7:0]);
      foreach (string_bytes[i]) send_byte(string_bytes[i]);
   endtask

   // push one well-formed character of at most room bytes
   task automatic add_char(input int room);
      int kind;
      kind = $urandom_range(1, (room < 3) ? room : 3);
      case (kind)
         1: string_bytes.push_back({1'b0, 7'($urandom_range(0, 127))});
         2: begin
            string_bytes.push_back({LEAD_TWO_TAG, 5'($urandom_range(0, 31))});
            string_bytes.push_back({CONT_TAG, 6'($urandom_range(0, 63))});
         end
         default: begin
            string_bytes.push_back({LEAD_THREE_TAG, 4'($urandom_range(0, 15))});
            string_bytes.push_back({CONT_TAG, 6'($urandom_range(0, 63))});
            string_bytes.push_back({CONT_TAG, 6'($urandom_range(0, 63))});
         end
      endcase
   endtask

   // bring the decoder back to waiting for a count, forcing an error if needed
   task automatic resync();
      while (dec_state.in_payload || dec_state.hdr_cnt != 2'd0) begin
         if (!dec_state.in_payload || dec_state.cont != 2'd0)
            send_byte(RESYNC_FILL);
         else
            send_byte(RESYNC_LEAD);
      end
   endtask

   task automatic test_directed();
      // zero count gives an empty-string result
      string_bytes.delete();
      send_string(32'h0000_0000);
      // largest count, null as two bytes, largest three-byte char, bad lead nibble
      string_bytes = '{8'h00, 8'hC0, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'h9A};
      send_string(32'hFFFF_FFFF);
      // three-byte sequence running past the count
      string_bytes = '{8'hE1};
      send_string(32'h0000_0002);
      // bad continuation byte after a two-byte lead
      string_bytes = '{8'h7F, 8'hDF, 8'h41};
      send_string(32'h0000_0005);
      resync();
      // strings ending on a two-byte and on a three-byte char
      string_bytes = '{8'h41, 8'hDF, 8'hBF};
      send_string(32'h0000_0003);
      string_bytes = '{8'hE0, 8'h80, 8'h80};
      send_string(32'h0000_0003);
      // nibble 15 lead
      string_bytes = '{8'hF5};
      send_string(32'h0000_0001);
   endtask

   // mostly well-formed strings, some broken, some noise, some huge counts
   task automatic test_random_strings(input int target);
      int          mode;
      int          len;
      int          idx;
      logic [31:0] count;
      while (items_sent < target) begin
         mode = $urandom_range(0, 99);
         string_bytes.delete();
         if (mode < 5) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
         end else begin
            len = (mode < 8) ? 0 : $urandom_range(1, 14);
            while (string_bytes.size() < len) add_char(len - string_bytes.size());
            count = string_bytes.size();
            if (mode >= 8 && mode < 16) begin
               // sequence that runs past the count
               if ($urandom_range(0, 1) == 0) begin
                  string_bytes.push_back({LEAD_TWO_TAG, 5'($urandom_range(0, 31))});
                  count = count + 1;
               end else begin
                  string_bytes.push_back({LEAD_THREE_TAG, 4'($urandom_range(0, 15))});
                  count = count + 1;
                  if ($urandom_range(0, 1) == 0) begin
                     string_bytes.push_back({CONT_TAG, 6'($urandom_range(0, 63))});
                     count = count + 1;
                  end
               end
            end else if (mode >= 16 && mode < 28 && string_bytes.size() > 0) begin
               // corrupt one byte
               idx = $urandom_range(0, string_bytes.size() - 1);
               string_bytes[idx] = 8'($urandom_range(0, 255));
            end else if (mode >= 28 && mode < 33) begin
               // count far beyond the payload sent
               count = $urandom();
               if (count < 32'd256) count = count + 32'd256;
            end
            send_string(count);
         end
         resync();
      end
   endtask

   // final stretch with no gaps and no stalls
   task automatic test_full_rate(input int target);
      idle_on = 1'b0;
      test_random_strings(target);
   endtask

   // result side: random stalls and checking against the oldest expectation
   always @(posedge clock) begin
      char_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected beat char_out %h status %0d eos %0d", $time,
                     rsp_char_out, rsp_status, rsp_end_of_string);
            errors++;
         end else begin
            want = pending_chars.pop_front();
            if (rsp_char_out !== want.ch) begin
               $display("%0t: char_out expected %h actual %h", $time, want.ch,
                        rsp_char_out);
               errors++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_status);
               errors++;
            end
            if (rsp_end_of_string !== want.eos) begin
               $display("%0t: end_of_string expected %0d actual %0d", $time, want.eos,
                        rsp_end_of_string);
               errors++;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 17);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // hang detection: cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, pending_chars.size());
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // main sequence
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_strings(RANDOM_ITEMS);
      test_full_rate(TOTAL_ITEMS);
      req_valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
